// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define EISE_ASSERT_CLK(label, ck, rst_n, prop, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define EISE_ASSERT(label, prop, msg) \
	`EISE_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ===== rtl/eise_pkg.sv =====
`default_nettype none

package eise_pkg;

	localparam int WINDOW = 10;
	localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int FILL_W = $clog2(WINDOW + 1);

	localparam int IV_W = 16;
	localparam int SUM_W = IV_W + ((WINDOW > 1) ? $clog2(WINDOW) : 0);
	localparam int L_W = 10;
	localparam int DB_W = 8;
	localparam int TIME_W = 32;
	localparam int COUNT_W = 32;
	localparam int SPEED_W = 18;
	localparam int DATA_W = 32;
	localparam int ADDR_W = 3;

	localparam int SPEED_LIMIT = 128000;
	localparam int SPEED_SCALE = 256000;
	localparam int RATE_K = 1000;
	localparam int LARGE_RESET = 100;
	localparam int DEBOUNCE_RESET = 2;

	// Serial divider sizing: numerator 2*256000*fill + |sum|, divisor 2*|sum|.
	localparam int NUM_W = $clog2(2 * SPEED_SCALE * WINDOW + 2 ** (SUM_W - 1) + 1);
	localparam int DEN_W = SUM_W + 1;
	localparam int PROD_W = L_W + SUM_W;

	localparam logic [1:0] FUNC_EDGE = 2'd0;
	localparam logic [1:0] FUNC_TICK = 2'd1;
	localparam logic [1:0] FUNC_PRELOAD = 2'd2;

	localparam logic REG_LARGE = 1'b0;
	localparam logic REG_DEBOUNCE = 1'b1;

	localparam logic [1:0] SIGN_ZERO = 2'b00;
	localparam logic [1:0] SIGN_POS = 2'b01;

	typedef struct packed {
		logic start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/eise_div.sv =====
`default_nettype none

module eise_div import eise_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic ge;

	// One restoring step a cycle; the numerator register fills with quotient bits.
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		diff = trial - {1'b0, den_q};
		ge = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = num_q;

endmodule

`default_nettype wire

// ===== rtl/encoder_interval_speed_estimator_core.sv =====
// Two-wheel encoder speed estimator.
// Input channel (in_valid / in_stall): func selects an encoder edge, a measurement
// tick or a preload interval; the other fields qualify it. Every transaction gives
// exactly one result transaction on the output channel (out_valid / out_stall) with
// both pulse counts, the three held speeds and the edge_taken flag.
// An edge passes S_EDGE, S_PUSH and S_DONE, where its result is loaded into the
// output register; a preload runs S_PUSH once per wheel, an edge rejected by the
// debounce skips S_PUSH and an unused func code goes straight to S_DONE. A tick runs
// the single serial divider (one quotient bit a cycle, 23 steps) up to three times,
// once for the low-speed threshold and once per wheel, with sequencer states around each run.
// A wheel whose speed reads as zero skips its division.
// The block takes one transaction at a time; in_stall is high from acceptance until
// its result has been moved into the output register. A result waiting under
// out_stall does not block the next input transaction, but a second result waits
// in the sequencer until the output register is free.
// Configuration (large interval at 0x0, debounce at 0x4) is written over the APB
// port by the user only while the block is idle; the block does not enforce this.
// Reads return the stored values. Reset clears the counts, edge times and speeds,
// and loads each wheel window with one entry of 100 ms.
`default_nettype none

module encoder_interval_speed_estimator_core import eise_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,

	input wire logic in_valid,
	output logic in_stall,
	input wire logic [1:0] func,
	input wire logic wheel_sel,
	input wire logic edge_level,
	input wire logic [TIME_W-1:0] now_ms,
	input wire logic signed [1:0] motor_sign,
	input wire logic signed [IV_W-1:0] preload_interval,

	output logic out_valid,
	input wire logic out_stall,
	output logic signed [COUNT_W-1:0] left_count,
	output logic signed [COUNT_W-1:0] right_count,
	output logic signed [SPEED_W-1:0] left_speed_q8,
	output logic signed [SPEED_W-1:0] right_speed_q8,
	output logic signed [SPEED_W-1:0] mean_speed_q8,
	output logic edge_taken,

	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [ADDR_W-1:0] paddr,
	input wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic pready
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_EDGE,
		S_PUSH,
		S_THR,
		S_THR_WAIT,
		S_STALL,
		S_SPD_A,
		S_SPD_B,
		S_SPD_C,
		S_SPD_WAIT,
		S_MEAN,
		S_DONE
	} state_t;

	state_t state_q;

	logic [L_W-1:0] large_q;
	logic [DB_W-1:0] debounce_q;

	logic [1:0] func_q;
	logic wheel_q;
	logic level_q;
	logic [TIME_W-1:0] now_q;
	logic [1:0] motor_sign_q;
	logic taken_q;

	logic [COUNT_W-1:0] count_q [2];
	logic [TIME_W-1:0] last_q [2][2];
	logic [IV_W-1:0] ring_q [2][WINDOW];
	logic [SUM_W-1:0] sum_q [2];
	logic [FILL_W-1:0] fill_q [2];
	logic [IDX_W-1:0] idx_q [2];
	logic [SPEED_W-1:0] spd_q [3];

	logic wsel_q;
	logic push_both_q;
	logic [IV_W-1:0] push_val_q;
	logic [L_W-1:0] thr_q;
	logic zero_q;
	logic neg_q;
	logic [SUM_W-1:0] mag_q;
	logic [PROD_W-1:0] prod_q;

	logic out_valid_q;
	logic [COUNT_W-1:0] out_left_count_q;
	logic [COUNT_W-1:0] out_right_count_q;
	logic [SPEED_W-1:0] out_left_speed_q;
	logic [SPEED_W-1:0] out_right_speed_q;
	logic [SPEED_W-1:0] out_mean_speed_q;
	logic out_taken_q;

	logic [L_W-1:0] eff_large;
	logic [TIME_W-1:0] edge_d;
	logic [TIME_W-1:0] stall_d;
	logic edge_ok;
	logic [IV_W:0] edge_neg;
	logic [IV_W-1:0] edge_iv;
	logic [COUNT_W-1:0] count_inc;
	logic [IV_W-1:0] ring_old;
	logic [SUM_W-1:0] sum_new;
	logic [SUM_W-1:0] cur_sum;
	logic [SUM_W-1:0] mag_c;
	logic spd_zero;
	logic [SPEED_W-1:0] speed_mag;
	logic [SPEED_W-1:0] speed_val;
	logic [SPEED_W:0] mean_t;
	logic [SPEED_W:0] mean_abs;
	logic [SPEED_W:0] mean_half;
	logic [SPEED_W:0] mean_neg;
	logic [SPEED_W-1:0] mean_val;
	logic in_accept;
	logic cfg_write;

	div_req_t div_req;
	div_rsp_t div_rsp;

	eise_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.rsp(div_rsp)
	);

	assign in_accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign cfg_write = psel && penable && pwrite;
	assign pready = 1'b1;

	// A zero stall interval behaves as one millisecond.
	assign eff_large = (large_q == '0) ? L_W'(1) : large_q;

	always_comb begin
		edge_d = now_q - last_q[wheel_q][level_q];
		stall_d = now_q - last_q[wsel_q][1];
		edge_ok = (edge_d >= TIME_W'(debounce_q));
		edge_neg = -edge_d[IV_W:0];
		unique case (motor_sign_q)
			SIGN_ZERO: begin
				edge_iv = IV_W'(eff_large);
				count_inc = '0;
			end
			SIGN_POS: begin
				edge_iv = (edge_d > TIME_W'(eff_large)) ? IV_W'(eff_large) : edge_d[IV_W-1:0];
				count_inc = COUNT_W'(1);
			end
			default: begin
				edge_iv = (edge_d > TIME_W'(2 ** (IV_W - 1))) ?
					{1'b1, {(IV_W - 1){1'b0}}} : edge_neg[IV_W-1:0];
				count_inc = '1;
			end
		endcase
	end

	always_comb begin
		ring_old = ring_q[wsel_q][idx_q[wsel_q]];
		sum_new = sum_q[wsel_q] - SUM_W'($signed(ring_old)) + SUM_W'($signed(push_val_q));
		cur_sum = sum_q[wsel_q];
		mag_c = cur_sum[SUM_W-1] ? -cur_sum : cur_sum;
		spd_zero = zero_q || (PROD_W'(RATE_K) * PROD_W'(fill_q[wsel_q]) < prod_q);
		speed_mag = (div_rsp.quo > NUM_W'(SPEED_LIMIT)) ?
			SPEED_W'(SPEED_LIMIT) : div_rsp.quo[SPEED_W-1:0];
		speed_val = neg_q ? -speed_mag : speed_mag;
	end

	// Mean of the two speeds, halved with ties rounded away from zero.
	always_comb begin
		mean_t = {spd_q[0][SPEED_W-1], spd_q[0]} + {spd_q[1][SPEED_W-1], spd_q[1]};
		mean_abs = mean_t[SPEED_W] ? -mean_t : mean_t;
		mean_half = (mean_abs + (SPEED_W + 1)'(1)) >> 1;
		mean_neg = -mean_half;
		mean_val = mean_t[SPEED_W] ? mean_neg[SPEED_W-1:0] : mean_half[SPEED_W-1:0];
	end

	always_comb begin
		div_req.start = 1'b0;
		div_req.num = NUM_W'(RATE_K);
		div_req.den = DEN_W'(eff_large);
		if (state_q == S_THR) begin
			div_req.start = 1'b1;
		end else if (state_q == S_SPD_C) begin
			div_req.start = !spd_zero;
			div_req.num = NUM_W'(2 * SPEED_SCALE) * NUM_W'(fill_q[wsel_q]) + NUM_W'(mag_q);
			div_req.den = {mag_q, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			large_q <= L_W'(LARGE_RESET);
			debounce_q <= DB_W'(DEBOUNCE_RESET);
		end else if (cfg_write) begin
			unique case (paddr[2])
				REG_LARGE: large_q <= pwdata[L_W-1:0];
				REG_DEBOUNCE: debounce_q <= pwdata[DB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_LARGE: prdata = DATA_W'(large_q);
			REG_DEBOUNCE: prdata = DATA_W'(debounce_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			func_q <= '0;
			wheel_q <= 1'b0;
			level_q <= 1'b0;
			now_q <= '0;
			motor_sign_q <= '0;
			taken_q <= 1'b0;
			wsel_q <= 1'b0;
			push_both_q <= 1'b0;
			push_val_q <= '0;
			thr_q <= '0;
			zero_q <= 1'b0;
			neg_q <= 1'b0;
			mag_q <= '0;
			prod_q <= '0;
			out_valid_q <= 1'b0;
			out_left_count_q <= '0;
			out_right_count_q <= '0;
			out_left_speed_q <= '0;
			out_right_speed_q <= '0;
			out_mean_speed_q <= '0;
			out_taken_q <= 1'b0;
			for (int w = 0; w < 2; w++) begin
				count_q[w] <= '0;
				last_q[w][0] <= '0;
				last_q[w][1] <= '0;
				sum_q[w] <= SUM_W'(LARGE_RESET);
				fill_q[w] <= FILL_W'(1);
				idx_q[w] <= IDX_W'(1 % WINDOW);
				for (int i = 0; i < WINDOW; i++) begin
					ring_q[w][i] <= (i == 0) ? IV_W'(LARGE_RESET) : '0;
				end
			end
			for (int k = 0; k < 3; k++) begin
				spd_q[k] <= '0;
			end
		end else begin
			// In S_DONE the output register is reloaded below instead of emptied.
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						func_q <= func;
						wheel_q <= wheel_sel;
						level_q <= edge_level;
						now_q <= now_ms;
						motor_sign_q <= motor_sign;
						taken_q <= 1'b0;
						unique case (func)
							FUNC_EDGE: state_q <= S_EDGE;
							FUNC_TICK: state_q <= S_THR;
							FUNC_PRELOAD: begin
								push_val_q <= preload_interval;
								wsel_q <= 1'b0;
								push_both_q <= 1'b1;
								state_q <= S_PUSH;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_EDGE: begin
					if (edge_ok) begin
						taken_q <= 1'b1;
						count_q[wheel_q] <= count_q[wheel_q] + count_inc;
						last_q[wheel_q][level_q] <= now_q;
						push_val_q <= edge_iv;
						wsel_q <= wheel_q;
						push_both_q <= 1'b0;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_PUSH: begin
					// The oldest entry leaves the window and the sum in the same cycle.
					ring_q[wsel_q][idx_q[wsel_q]] <= push_val_q;
					sum_q[wsel_q] <= sum_new;
					idx_q[wsel_q] <= (idx_q[wsel_q] == IDX_W'(WINDOW - 1)) ?
						'0 : idx_q[wsel_q] + IDX_W'(1);
					if (fill_q[wsel_q] < FILL_W'(WINDOW)) begin
						fill_q[wsel_q] <= fill_q[wsel_q] + FILL_W'(1);
					end
					if (push_both_q && !wsel_q) begin
						wsel_q <= 1'b1;
					end else if (func_q == FUNC_TICK) begin
						state_q <= S_SPD_A;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_THR: begin
					state_q <= S_THR_WAIT;
				end
				S_THR_WAIT: begin
					if (div_rsp.done) begin
						thr_q <= div_rsp.quo[L_W-1:0];
						wsel_q <= 1'b0;
						state_q <= S_STALL;
					end
				end
				S_STALL: begin
					if (stall_d > TIME_W'(eff_large)) begin
						push_val_q <= IV_W'({eff_large, 1'b0});
						push_both_q <= 1'b0;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_SPD_A;
					end
				end
				S_SPD_A: begin
					zero_q <= (cur_sum == '0);
					neg_q <= cur_sum[SUM_W-1];
					mag_q <= mag_c;
					state_q <= S_SPD_B;
				end
				S_SPD_B: begin
					prod_q <= PROD_W'(thr_q) * PROD_W'(mag_q);
					state_q <= S_SPD_C;
				end
				S_SPD_C: begin
					if (spd_zero) begin
						spd_q[wsel_q] <= '0;
						if (!wsel_q) begin
							wsel_q <= 1'b1;
							state_q <= S_STALL;
						end else begin
							state_q <= S_MEAN;
						end
					end else begin
						state_q <= S_SPD_WAIT;
					end
				end
				S_SPD_WAIT: begin
					if (div_rsp.done) begin
						spd_q[wsel_q] <= speed_val;
						if (!wsel_q) begin
							wsel_q <= 1'b1;
							state_q <= S_STALL;
						end else begin
							state_q <= S_MEAN;
						end
					end
				end
				S_MEAN: begin
					spd_q[2] <= mean_val;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_left_count_q <= count_q[0];
						out_right_count_q <= count_q[1];
						out_left_speed_q <= spd_q[0];
						out_right_speed_q <= spd_q[1];
						out_mean_speed_q <= spd_q[2];
						out_taken_q <= taken_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign left_count = out_left_count_q;
	assign right_count = out_right_count_q;
	assign left_speed_q8 = out_left_speed_q;
	assign right_speed_q8 = out_right_speed_q;
	assign mean_speed_q8 = out_mean_speed_q;
	assign edge_taken = out_taken_q;

endmodule

`default_nettype wire

// ===== rtl/eise_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module eise_checker import eise_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_stall,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic signed [COUNT_W-1:0] left_count,
	input wire logic signed [SPEED_W-1:0] left_speed_q8,
	input wire logic signed [SPEED_W-1:0] right_speed_q8,
	input wire logic signed [SPEED_W-1:0] mean_speed_q8
);

	// Every transaction runs through the sequencer, so the input side closes at once.
	`EISE_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "input not stalled after a transaction")

	`EISE_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(left_count) && $stable(mean_speed_q8), "stalled result changed")

	`EISE_ASSERT(a_speed_range, out_valid |-> left_speed_q8 <= SPEED_LIMIT && left_speed_q8 >= -SPEED_LIMIT && right_speed_q8 <= SPEED_LIMIT && right_speed_q8 >= -SPEED_LIMIT, "speed beyond saturation limit")

	`EISE_ASSERT(a_mean_zero, out_valid && left_speed_q8 == 0 && right_speed_q8 == 0 |-> mean_speed_q8 == 0, "mean of two zero speeds is not zero")

endmodule

bind encoder_interval_speed_estimator_core eise_checker u_eise_checker (.*);

`default_nettype wire
